[hw/rtl/maf_pkg.sv]
// maf_pkg: widths, register indexes and window helper of the moving average filter
// used by the channel interfaces and by moving_average_filter; no dependencies
package maf_pkg;

    // payload widths
    localparam int SAMPLE_W   = 48;
    localparam int TIME_W     = 63;
    localparam int SUM_W      = 58;
    localparam int WIN_W      = 11;
    localparam int MAX_WINDOW = 1024;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int ALPHA_W    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE  = CFG_IDX_W'(1);

    // average modes
    localparam logic MODE_SMA = 1'b0;
    localparam logic MODE_EMA = 1'b1;

    // width of the shared adder
    localparam int ALU_W = 60;

    // window length as used: zero acts as one, long windows clip
    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        if (w == '0)
            r = WIN_W'(1);
        else if (w > WIN_W'(MAX_WINDOW))
            r = WIN_W'(MAX_WINDOW);
        else
            r = w;
        return r;
    endfunction

endpackage

[hw/rtl/maf_sample_if.sv]
// maf_sample_if: input channel carrying one timestamped sample per request
// depends on maf_pkg for field widths
interface maf_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [maf_pkg::SAMPLE_W-1:0] sample_value;
    logic        [maf_pkg::TIME_W-1:0]   sample_time;
    logic                                series_start;

    modport source (output valid, sample_value, sample_time, series_start, input ready);
    modport sink   (input valid, sample_value, sample_time, series_start, output ready);
endinterface

[hw/rtl/maf_average_if.sv]
// maf_average_if: output channel carrying one average per request
// depends on maf_pkg for field widths
interface maf_average_if;
    logic                                valid;
    logic                                ready;
    logic signed [maf_pkg::SAMPLE_W-1:0] average_value;
    logic        [maf_pkg::TIME_W-1:0]   average_time;

    modport source (output valid, average_value, average_time, input ready);
    modport sink   (input valid, average_value, average_time, output ready);
endinterface

[hw/rtl/maf_cfg_if.sv]
// maf_cfg_if: register write channel, one register index and data word per request
// depends on maf_pkg for field widths
interface maf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [maf_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [maf_pkg::CFG_DATA_W-1:0]    reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

[hw/rtl/moving_average_filter.sv]
// moving_average_filter: simple / exponential moving average over a sample ring
// depends on maf_pkg, maf_sample_if, maf_average_if and maf_cfg_if
//
// Usage
//   cfg: register 0 is the window length N (0 acts as 1, above 1024 acts as 1024),
//   register 1 the mode (0 simple, 1 exponential). A write to either register clears
//   the series and recomputes alpha = 2^33/(N+1) with the shared divider, during which
//   neither channel is ready. Writes go in only while the block is idle.
//   sample_in: one sample per request; series_start clears the series first. The
//   block takes one request at a time and is not ready until it has finished it.
//   average_out: one result per sample once N samples have arrived since the clear.
// Sequence (all arithmetic on the single shared adder under the sequencer)
//   no result: read the ring, drop the oldest sample, add the new one
//   simple average or first exponential value: 58-step restoring divide, then sign
//   later exponential values: 32-step shift-add multiply, skipped when N = 1
// The result sits in an output register; the next sample is taken while it waits.
// If the receiver stalls and a new result is ready, the sequencer holds until the
// output register frees. Reset clears the series and sets N = 1, simple mode; the
// ring is read only where it was written, so it needs no clearing pass.
module moving_average_filter (
    input  logic           clk,
    input  logic           rst_n,
    maf_cfg_if.sink        cfg,
    maf_sample_if.sink     sample_in,
    maf_average_if.source  average_out
);

    localparam int STEP_W = 6;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_SUB  = 4'd2;
    localparam logic [3:0] S_ADD  = 4'd3;
    localparam logic [3:0] S_ABS  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_SIGN = 4'd6;
    localparam logic [3:0] S_DIFF = 4'd7;
    localparam logic [3:0] S_DABS = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(maf_pkg::SUM_W - 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(maf_pkg::ALPHA_W - 1);

    logic [3:0]                      state_reg;
    logic [maf_pkg::WIN_W-1:0]       win_reg;
    logic                            mode_reg;
    logic [maf_pkg::ALPHA_W-1:0]     alpha_reg;
    logic [maf_pkg::SUM_W-1:0]       sum_reg;
    logic [maf_pkg::WIN_W-1:0]       fill_reg;
    logic [maf_pkg::PTR_W-1:0]       ptr_reg;
    logic [maf_pkg::SAMPLE_W-1:0]    prev_reg;
    logic                            full_reg;
    logic [maf_pkg::SAMPLE_W-1:0]    x_reg;
    logic [maf_pkg::TIME_W-1:0]      t_reg;
    logic [maf_pkg::SAMPLE_W-1:0]    rd_reg;

    // divider and multiplier working registers
    logic [maf_pkg::SUM_W-1:0]       div_q_reg;
    logic [maf_pkg::WIN_W-1:0]       div_r_reg;
    logic [maf_pkg::WIN_W-1:0]       div_d_reg;
    logic                            div_neg_reg;
    logic                            div_alpha_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [maf_pkg::SAMPLE_W:0]      diff_reg;
    logic [maf_pkg::SAMPLE_W:0]      acc_hi_reg;
    logic [maf_pkg::ALPHA_W-1:0]     acc_lo_reg;
    logic [maf_pkg::ALPHA_W-1:0]     mul_b_reg;

    // output register
    logic                            out_valid_reg;
    logic [maf_pkg::SAMPLE_W-1:0]    out_value_reg;
    logic [maf_pkg::TIME_W-1:0]      out_time_reg;

    // sample ring
    logic [maf_pkg::SAMPLE_W-1:0]    ring_mem [maf_pkg::MAX_WINDOW];

    logic [maf_pkg::ALU_W-1:0]       alu_a;
    logic [maf_pkg::ALU_W-1:0]       alu_b;
    logic                            alu_cin;
    logic [maf_pkg::ALU_W-1:0]       alu_sum;

    logic                            cfg_fire;
    logic                            in_fire;
    logic                            out_free;
    logic                            out_load;
    logic                            n_one;
    logic                            diff_neg;
    logic [maf_pkg::WIN_W:0]         div_trial;
    logic                            div_ge;
    logic [maf_pkg::WIN_W-1:0]       cfg_win;
    logic [maf_pkg::WIN_W-1:0]       ptr_inc;
    logic [maf_pkg::WIN_W-1:0]       fill_inc;
    logic                            emit;
    logic [maf_pkg::SAMPLE_W-1:0]    fin_value;

    // handshakes
    assign cfg.ready       = (state_reg == S_IDLE);
    assign sample_in.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg_fire        = cfg.valid && cfg.ready;
    assign in_fire         = sample_in.valid && sample_in.ready;
    assign out_free        = !out_valid_reg || average_out.ready;
    assign out_load        = ((state_reg == S_SIGN) || (state_reg == S_FIN)) && out_free;

    assign average_out.valid         = out_valid_reg;
    assign average_out.average_value = out_value_reg;
    assign average_out.average_time  = out_time_reg;

    // small helpers
    assign n_one     = (win_reg == maf_pkg::WIN_W'(1));
    assign diff_neg  = diff_reg[maf_pkg::SAMPLE_W];
    assign div_trial = {div_r_reg, div_q_reg[maf_pkg::SUM_W-1]};
    assign div_ge    = !alu_sum[maf_pkg::ALU_W-1];
    assign cfg_win   = maf_pkg::eff_window(cfg.reg_data);
    assign ptr_inc   = maf_pkg::WIN_W'(ptr_reg) + maf_pkg::WIN_W'(1);
    assign fill_inc  = fill_reg + maf_pkg::WIN_W'(1);
    assign emit      = full_reg || (fill_inc >= win_reg);
    assign fin_value = n_one ? x_reg : alu_sum[maf_pkg::SAMPLE_W-1:0];

    // shared adder operand selection
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        case (state_reg)
            S_SUB:
            begin
                alu_a   = {{(maf_pkg::ALU_W-maf_pkg::SUM_W){sum_reg[maf_pkg::SUM_W-1]}},
                           sum_reg};
                alu_b   = full_reg ?
                          ~{{(maf_pkg::ALU_W-maf_pkg::SAMPLE_W){rd_reg[maf_pkg::SAMPLE_W-1]}},
                            rd_reg} : '1;
                alu_cin = 1'b1;
            end
            S_ADD:
            begin
                alu_a   = {{(maf_pkg::ALU_W-maf_pkg::SUM_W){sum_reg[maf_pkg::SUM_W-1]}},
                           sum_reg};
                alu_b   = {{(maf_pkg::ALU_W-maf_pkg::SAMPLE_W){x_reg[maf_pkg::SAMPLE_W-1]}},
                           x_reg};
            end
            S_ABS:
            begin
                alu_b   = sum_reg[maf_pkg::SUM_W-1] ? ~maf_pkg::ALU_W'(sum_reg)
                                                    : maf_pkg::ALU_W'(sum_reg);
                alu_cin = sum_reg[maf_pkg::SUM_W-1];
            end
            S_DIV:
            begin
                alu_a   = maf_pkg::ALU_W'(div_trial);
                alu_b   = ~maf_pkg::ALU_W'(div_d_reg);
                alu_cin = 1'b1;
            end
            S_SIGN:
            begin
                alu_b   = div_neg_reg ? ~maf_pkg::ALU_W'(div_q_reg)
                                      : maf_pkg::ALU_W'(div_q_reg);
                alu_cin = div_neg_reg;
            end
            S_DIFF:
            begin
                alu_a   = {{(maf_pkg::ALU_W-maf_pkg::SAMPLE_W){x_reg[maf_pkg::SAMPLE_W-1]}},
                           x_reg};
                alu_b   = ~{{(maf_pkg::ALU_W-maf_pkg::SAMPLE_W){prev_reg[maf_pkg::SAMPLE_W-1]}},
                            prev_reg};
                alu_cin = 1'b1;
            end
            S_DABS:
            begin
                alu_b   = diff_neg ? ~maf_pkg::ALU_W'(diff_reg) : maf_pkg::ALU_W'(diff_reg);
                alu_cin = diff_neg;
            end
            S_MUL:
            begin
                alu_a   = maf_pkg::ALU_W'(acc_hi_reg);
                alu_b   = mul_b_reg[0] ? maf_pkg::ALU_W'(diff_reg) : '0;
            end
            S_FIN:
            begin
                alu_a   = {{(maf_pkg::ALU_W-maf_pkg::SAMPLE_W){prev_reg[maf_pkg::SAMPLE_W-1]}},
                           prev_reg};
                alu_b   = diff_neg ? ~maf_pkg::ALU_W'(acc_hi_reg) : maf_pkg::ALU_W'(acc_hi_reg);
                alu_cin = diff_neg && (acc_lo_reg == '0);
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_cin = 1'b0;
            end
        endcase
        alu_sum = alu_a + alu_b + maf_pkg::ALU_W'(alu_cin);
    end

    // sample ring: registered read in S_READ, write in S_SUB
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            rd_reg <= ring_mem[ptr_reg];
        if (state_reg == S_SUB)
            ring_mem[ptr_reg] <= x_reg;
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= maf_pkg::WIN_W'(1);
            mode_reg      <= maf_pkg::MODE_SMA;
            alpha_reg     <= '0;
            sum_reg       <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            prev_reg      <= '0;
            full_reg      <= 1'b0;
            x_reg         <= '0;
            t_reg         <= '0;
            div_q_reg     <= '0;
            div_r_reg     <= '0;
            div_d_reg     <= maf_pkg::WIN_W'(1);
            div_neg_reg   <= 1'b0;
            div_alpha_reg <= 1'b0;
            step_reg      <= '0;
            diff_reg      <= '0;
            acc_hi_reg    <= '0;
            acc_lo_reg    <= '0;
            mul_b_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_time_reg  <= '0;
        end
        else
        begin
            // output register loads a new result or drains
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && average_out.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        if (cfg.reg_index == maf_pkg::REG_WINDOW_LENGTH ||
                            cfg.reg_index == maf_pkg::REG_AVERAGE_MODE)
                        begin
                            // clear series and start the alpha divide
                            sum_reg       <= '0;
                            fill_reg      <= '0;
                            ptr_reg       <= '0;
                            prev_reg      <= '0;
                            div_q_reg     <= maf_pkg::SUM_W'(1) << (maf_pkg::ALPHA_W + 1);
                            div_r_reg     <= '0;
                            div_alpha_reg <= 1'b1;
                            step_reg      <= '0;
                            state_reg     <= S_DIV;
                            if (cfg.reg_index == maf_pkg::REG_WINDOW_LENGTH)
                            begin
                                win_reg   <= cfg_win;
                                div_d_reg <= cfg_win + maf_pkg::WIN_W'(1);
                            end
                            else
                            begin
                                mode_reg  <= cfg.reg_data[0];
                                div_d_reg <= win_reg + maf_pkg::WIN_W'(1);
                            end
                        end
                    end
                    else if (in_fire)
                    begin
                        x_reg     <= sample_in.sample_value;
                        t_reg     <= sample_in.sample_time;
                        state_reg <= S_READ;
                        if (sample_in.series_start)
                        begin
                            sum_reg  <= '0;
                            fill_reg <= '0;
                            ptr_reg  <= '0;
                            prev_reg <= '0;
                        end
                    end
                end
                S_READ:
                begin
                    full_reg  <= (fill_reg >= win_reg);
                    state_reg <= S_SUB;
                end
                S_SUB:
                begin
                    // drop the oldest sample once the window is full
                    sum_reg   <= alu_sum[maf_pkg::SUM_W-1:0];
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    sum_reg <= alu_sum[maf_pkg::SUM_W-1:0];
                    ptr_reg <= (ptr_inc >= win_reg) ? '0 : ptr_inc[maf_pkg::PTR_W-1:0];
                    if (!full_reg)
                        fill_reg <= fill_inc;
                    if (!emit)
                        state_reg <= S_IDLE;
                    else if (mode_reg == maf_pkg::MODE_SMA || !full_reg)
                        state_reg <= S_ABS;
                    else if (n_one)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_DIFF;
                end
                S_ABS:
                begin
                    div_neg_reg   <= sum_reg[maf_pkg::SUM_W-1];
                    div_q_reg     <= alu_sum[maf_pkg::SUM_W-1:0];
                    div_r_reg     <= '0;
                    div_d_reg     <= win_reg;
                    div_alpha_reg <= 1'b0;
                    step_reg      <= '0;
                    state_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    // one restoring step per cycle
                    div_r_reg <= div_ge ? alu_sum[maf_pkg::WIN_W-1:0]
                                        : div_trial[maf_pkg::WIN_W-1:0];
                    div_q_reg <= {div_q_reg[maf_pkg::SUM_W-2:0], div_ge};
                    step_reg  <= step_reg + STEP_W'(1);
                    if (step_reg == DIV_LAST)
                    begin
                        if (div_alpha_reg)
                        begin
                            alpha_reg <= (div_d_reg <= maf_pkg::WIN_W'(2)) ? '0 :
                                         {div_q_reg[maf_pkg::ALPHA_W-2:0], div_ge};
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_SIGN;
                    end
                end
                S_SIGN:
                begin
                    if (out_free)
                    begin
                        out_value_reg <= alu_sum[maf_pkg::SAMPLE_W-1:0];
                        out_time_reg  <= t_reg;
                        prev_reg      <= alu_sum[maf_pkg::SAMPLE_W-1:0];
                        state_reg     <= S_IDLE;
                    end
                end
                S_DIFF:
                begin
                    diff_reg  <= alu_sum[maf_pkg::SAMPLE_W:0];
                    state_reg <= S_DABS;
                end
                S_DABS:
                begin
                    // diff_reg takes the magnitude, its sign waits in div_neg_reg
                    diff_reg   <= alu_sum[maf_pkg::SAMPLE_W:0];
                    div_neg_reg <= diff_neg;
                    acc_hi_reg <= '0;
                    acc_lo_reg <= '0;
                    mul_b_reg  <= alpha_reg;
                    step_reg   <= '0;
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    // shift-add multiply, product shifts right into acc_lo
                    acc_hi_reg <= alu_sum[maf_pkg::SAMPLE_W+1:1];
                    acc_lo_reg <= {alu_sum[0], acc_lo_reg[maf_pkg::ALPHA_W-1:1]};
                    mul_b_reg  <= mul_b_reg >> 1;
                    step_reg   <= step_reg + STEP_W'(1);
                    if (step_reg == MUL_LAST)
                    begin
                        diff_reg  <= {div_neg_reg, maf_pkg::SAMPLE_W'(0)};
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_value_reg <= fin_value;
                        out_time_reg  <= t_reg;
                        prev_reg      <= fin_value;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[bench/testbench.sv]
// testbench: drives samples and register writes into moving_average_filter and
// checks every average against a built-in predictor of the simple and exponential modes
// depends on maf_pkg, maf_cfg_if, maf_sample_if, maf_average_if and moving_average_filter
`timescale 1ns / 1ps

module testbench;

    // widths taken from the package
    localparam int SAMPLE_W   = maf_pkg::SAMPLE_W;
    localparam int TIME_W     = maf_pkg::TIME_W;
    localparam int WIN_W      = maf_pkg::WIN_W;
    localparam int ALPHA_W    = maf_pkg::ALPHA_W;
    localparam int MAX_WINDOW = maf_pkg::MAX_WINDOW;
    localparam int CFG_IDX_W  = maf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = maf_pkg::CFG_DATA_W;

    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RESET_CYCLES = 9;
    localparam int LONG_WINDOW  = 250;
    localparam int LONG_RUN     = LONG_WINDOW + 10;
    localparam int CLIP_RUN     = 20;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS  = 50;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = '1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [TIME_W-1:0]          TIME_MAX   = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [TIME_W-1:0]   stamp;
    } average_rec_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    maf_cfg_if     cfg_ch ();
    maf_sample_if  sample_ch ();
    maf_average_if average_ch ();

    moving_average_filter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .sample_in   (sample_ch),
        .average_out (average_ch)
    );

    always #1 clk = ~clk;

    // predicted filter state
    logic signed [SAMPLE_W-1:0] win_ring [MAX_WINDOW];
    longint                     run_sum;
    int unsigned                filled;
    int unsigned                slot;
    logic signed [SAMPLE_W-1:0] ema_last;
    logic [ALPHA_W-1:0]         ema_weight;
    logic [WIN_W-1:0]           cfg_window = WIN_W'(1);
    logic                       cfg_mode   = maf_pkg::MODE_SMA;

    average_rec_t averages_due [$];
    average_rec_t head;
    int unsigned  mismatches  = 0;
    int unsigned  stall_left  = 0;
    int unsigned  quiet_cycles = 0;
    bit           steady      = 1'b0;

    // window as the block uses it: zero acts as one, long windows clip
    function automatic int unsigned window_in_use();
        if (cfg_window == '0)
            return 1;
        if (cfg_window > MAX_WINDOW)
            return MAX_WINDOW;
        return cfg_window;
    endfunction

    function automatic void restart_series();
        int unsigned n;
        n = window_in_use();
        run_sum  = 0;
        filled   = 0;
        slot     = 0;
        ema_last = '0;
        if (n <= 1)
            ema_weight = '0;
        else
            ema_weight = ALPHA_W'((64'd1 << 33) / 64'(n + 1));
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        if (idx == maf_pkg::REG_WINDOW_LENGTH)
            cfg_window = data[WIN_W-1:0];
        else if (idx == maf_pkg::REG_AVERAGE_MODE)
            cfg_mode = data[0];
        else
            return;
        restart_series();
    endfunction

    // take one sample into the ring and queue the average it produces, if any
    function automatic void advance_series(input logic signed [SAMPLE_W-1:0] x,
                                           input logic [TIME_W-1:0] t,
                                           input logic start);
        int unsigned                n;
        bit                         was_full;
        logic signed [SAMPLE_W-1:0] level;
        logic signed [95:0]         diff;
        logic signed [95:0]         weight;
        logic signed [95:0]         step;
        logic signed [95:0]         acc;
        average_rec_t               rec;
        n = window_in_use();
        if (start)
            restart_series();
        was_full = (filled >= n);
        if (was_full)
            run_sum -= longint'(win_ring[slot]);
        win_ring[slot] = x;
        run_sum += longint'(x);
        slot = (slot + 1 >= n) ? 0 : slot + 1;
        if (!was_full)
            filled++;
        if (filled < n)
            return;

        if (cfg_mode == maf_pkg::MODE_SMA || !was_full)
        begin
            // quotient truncated toward zero; seeds the exponential value too
            level = SAMPLE_W'(run_sum / longint'(n));
            if (cfg_mode == maf_pkg::MODE_EMA)
                ema_last = level;
        end
        else
        begin
            if (n <= 1)
                ema_last = x;
            else
            begin
                // floored product of the difference and alpha in Q0.32
                diff     = x - ema_last;
                weight   = {64'd0, ema_weight};
                step     = diff * weight;
                acc      = ema_last + (step >>> 32);
                ema_last = acc[SAMPLE_W-1:0];
            end
            level = ema_last;
        end
        rec.value = level;
        rec.stamp = t;
        averages_due.insert(averages_due.size(), rec);
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic [63:0] raw;
        int unsigned pick;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return SAMPLE_MAX;
        if (pick == 1)
            return SAMPLE_MIN;
        if (pick < 7)
            return SAMPLE_W'($signed(raw[20:0]));
        return raw[SAMPLE_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TIME_W-1:0];
    endfunction

    // one sample request; valid stays high so back-to-back requests need no gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value,
                               input logic [TIME_W-1:0] stamp,
                               input logic start);
        int unsigned pause;
        pause = gap_len();
        if (pause != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        sample_ch.sample_value <= value;
        sample_ch.sample_time  <= stamp;
        sample_ch.series_start <= start;
        sample_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        advance_series(value, stamp, start);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= data;
        cfg_ch.valid     <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        apply_register(idx, data);
    endtask

    // stop sending, wait for every due average, then let the block go idle
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (averages_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [WIN_W-1:0] window, input logic mode);
        settle();
        write_register(maf_pkg::REG_WINDOW_LENGTH, CFG_DATA_W'(window));
        settle();
        write_register(maf_pkg::REG_AVERAGE_MODE, CFG_DATA_W'(mode));
    endtask

    // window of one, simple mode, straight after reset
    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX, '0, 1'b0);
        send_sample(SAMPLE_MIN, TIME_MAX, 1'b0);
        send_sample('0, TIME_W'(1), 1'b1);
        send_sample(-SAMPLE_W'(1), TIME_W'(2), 1'b0);
    endtask

    // negative sums truncate toward zero
    task automatic test_simple_rounding();
        configure(WIN_W'(3), maf_pkg::MODE_SMA);
        send_sample(-SAMPLE_W'(1), TIME_W'(10), 1'b0);
        send_sample(-SAMPLE_W'(1), TIME_W'(11), 1'b0);
        send_sample('0, TIME_W'(12), 1'b0);
        send_sample(-SAMPLE_W'(5), TIME_W'(13), 1'b0);
        send_sample(SAMPLE_MIN, TIME_W'(14), 1'b0);
    endtask

    // first value is the simple average, then floored updates both ways
    task automatic test_exponential_update();
        configure(WIN_W'(3), maf_pkg::MODE_EMA);
        send_sample(SAMPLE_W'(100), TIME_W'(20), 1'b0);
        send_sample(SAMPLE_W'(200), TIME_W'(21), 1'b0);
        send_sample(SAMPLE_W'(301), TIME_W'(22), 1'b0);
        send_sample(-SAMPLE_W'(1), TIME_W'(23), 1'b0);
        send_sample(SAMPLE_MAX, TIME_W'(24), 1'b0);
        send_sample(SAMPLE_MIN, TIME_W'(25), 1'b0);
    endtask

    // zero window acts as one; exponential value follows the sample
    task automatic test_window_zero();
        configure('0, maf_pkg::MODE_EMA);
        send_sample(SAMPLE_W'(10), TIME_W'(30), 1'b0);
        send_sample(SAMPLE_MIN, TIME_W'(31), 1'b0);
        send_sample(SAMPLE_W'(7), TIME_W'(32), 1'b0);
    endtask

    // both a register write and series_start restart the fill
    task automatic test_clear_paths();
        configure(WIN_W'(3), maf_pkg::MODE_SMA);
        send_sample(SAMPLE_W'(1000), TIME_W'(40), 1'b0);
        send_sample(SAMPLE_W'(2000), TIME_W'(41), 1'b0);
        settle();
        write_register(maf_pkg::REG_AVERAGE_MODE, CFG_DATA_W'(maf_pkg::MODE_SMA));
        send_sample(SAMPLE_W'(3), TIME_W'(42), 1'b0);
        send_sample(SAMPLE_W'(4), TIME_W'(43), 1'b0);
        send_sample(SAMPLE_W'(5), TIME_W'(44), 1'b0);
        send_sample(SAMPLE_W'(60), TIME_W'(45), 1'b1);
        send_sample(SAMPLE_W'(70), TIME_W'(46), 1'b0);
    endtask

    // writes past the register list leave the series alone
    task automatic test_unmapped_register();
        configure(WIN_W'(2), maf_pkg::MODE_SMA);
        send_sample(SAMPLE_W'(-9), TIME_W'(50), 1'b0);
        settle();
        write_register(REG_UNMAPPED_LAST, '1);
        settle();
        write_register(REG_UNMAPPED_FIRST, '0);
        send_sample(SAMPLE_W'(4), TIME_W'(51), 1'b0);
    endtask

    // long window with ring wrap, and a length beyond the maximum that clips
    task automatic test_long_window();
        int unsigned k;
        configure(WIN_W'(LONG_WINDOW), maf_pkg::MODE_SMA);
        for (k = 0; k < LONG_RUN; k++)
            send_sample(random_sample(), random_stamp(), 1'b0);
        configure('1, maf_pkg::MODE_EMA);
        for (k = 0; k < CLIP_RUN; k++)
            send_sample(random_sample(), random_stamp(), 1'b0);
    endtask

    // random settings, mostly short windows, occasional restarts
    task automatic test_random_series();
        int unsigned      phase;
        int unsigned      k;
        int unsigned      pick;
        logic [WIN_W-1:0] window;
        logic             mode;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                window = '0;
            else if (pick < 8)
                window = WIN_W'($urandom_range(1, 8));
            else
                window = WIN_W'($urandom_range(9, 40));
            mode = 1'($urandom_range(0, 1));
            configure(window, mode);
            steady = (phase % 4 == 3);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_sample(random_sample(), random_stamp(), $urandom_range(0, 59) == 0);
            steady = 1'b0;
        end
    endtask

    // result receiver with random stalls
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            average_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            average_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left <= gap_len();
        end
    end

    // compare each accepted average with the oldest one due
    always @(posedge clk)
    begin
        if (average_ch.valid === 1'b1 && average_ch.ready === 1'b1)
        begin
            if (averages_due.size() == 0)
            begin
                $display("%0t: average with none due, got value %0d time %0d", $time,
                         $signed(average_ch.average_value), average_ch.average_time);
                mismatches++;
            end
            else
            begin
                head = averages_due.pop_front();
                if (average_ch.average_value !== head.value)
                begin
                    $display("%0t: average_value expected %0d got %0d", $time,
                             $signed(head.value), $signed(average_ch.average_value));
                    mismatches++;
                end
                if (average_ch.average_time !== head.stamp)
                begin
                    $display("%0t: average_time expected %0d got %0d", $time,
                             head.stamp, average_ch.average_time);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no request on any channel
    always @(posedge clk)
    begin
        if ((cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) ||
            (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
            (average_ch.valid === 1'b1 && average_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request for %0d cycles", $time, quiet_cycles);
            $display("testbench NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // sequence of tests
    initial
    begin
        rst_n                  <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.reg_index       <= '0;
        cfg_ch.reg_data        <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        sample_ch.sample_time  <= '0;
        sample_ch.series_start <= 1'b0;
        restart_series();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_simple_rounding();
        test_exponential_update();
        test_window_zero();
        test_clear_paths();
        test_unmapped_register();
        test_long_window();
        test_random_series();
        settle();

        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[files.f]
hw/rtl/maf_pkg.sv
hw/rtl/maf_sample_if.sv
hw/rtl/maf_average_if.sv
hw/rtl/maf_cfg_if.sv
hw/rtl/moving_average_filter.sv
bench/testbench.sv
